[rtl/peak_trough_detector_top_assert.svh]
// Assertion macros of the peak and trough detector checker.
`ifndef PEAK_TROUGH_DETECTOR_TOP_ASSERT_SVH
`define PEAK_TROUGH_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTD_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("peak_trough_detector assertion failed");

// Next-cycle implication, checked outside reset.
`define PTD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("peak_trough_detector assertion failed");

// Next-cycle implication that is also checked across reset.
`define PTD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("peak_trough_detector assertion failed");

`endif

[rtl/ptd_pkg.sv]
// Shared types and constants of the peak and trough detector.
`default_nettype none
package ptd_pkg;

   localparam int unsigned SampleWidth   = 16;
   localparam int unsigned RunWidth      = 16;
   localparam int unsigned PositionWidth = 32;

   localparam logic [RunWidth-1:0] MinRunReset = RunWidth'(4);
   localparam logic [RunWidth-1:0] RunMax      = {RunWidth{1'b1}};

   // Kind codes of a reported extremum.
   typedef enum logic {
      KIND_PEAK   = 1'b0,
      KIND_TROUGH = 1'b1
   } kind_type;

   // One result beat.
   typedef struct packed {
      logic                            found;
      kind_type                        kind;
      logic signed [SampleWidth-1:0]   extremum_value;
      logic [PositionWidth-1:0]        position;
   } result_type;

endpackage
`default_nettype wire

[rtl/ptd_tracker.sv]
// Sample history, direction and run tracking with extremum decision.
`default_nettype none
module ptd_tracker (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   advance,
   input  wire logic signed [ptd_pkg::SampleWidth-1:0] sample,
   input  wire logic [ptd_pkg::RunWidth-1:0]     min_run,
   output ptd_pkg::result_type                   result
);
   import ptd_pkg::*;

   logic signed [SampleWidth-1:0] older_ff, older_in;
   logic signed [SampleWidth-1:0] newer_ff, newer_in;
   logic                          rising_ff, rising_in;
   logic [RunWidth-1:0]           run_ff, run_in;
   logic [PositionWidth-1:0]      position_ff, position_in;

   logic peak_break;
   logic trough_break;
   logic qualified;

   // A rise breaks on a drop and a fall breaks on a climb; equal samples continue the run.
   assign peak_break   = rising_ff && (older_ff > newer_ff);
   assign trough_break = !rising_ff && (older_ff < newer_ff);
   assign qualified    = run_ff > min_run;

   // Result for the sample now being taken; fields stay zero without an extremum.
   always_comb begin
      result = '0;
      if ((peak_break || trough_break) && qualified) begin
         result.found          = 1'b1;
         result.kind           = peak_break ? KIND_PEAK : KIND_TROUGH;
         result.extremum_value = older_ff;
         result.position       = position_ff;
      end
   end

   // Next state: flip direction on a break, restart or saturate the run, shift the samples.
   always_comb begin
      rising_in   = rising_ff;
      run_in      = run_ff;
      older_in    = older_ff;
      newer_in    = newer_ff;
      position_in = position_ff;
      if (advance) begin
         if (peak_break || trough_break) begin
            rising_in = !rising_ff;
            run_in    = RunWidth'(1);
         end else if (run_ff != RunMax) begin
            run_in = run_ff + RunWidth'(1);
         end
         older_in    = newer_ff;
         newer_in    = sample;
         position_in = position_ff + PositionWidth'(1);
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff    <= '0;
         newer_ff    <= '0;
         rising_ff   <= 1'b1;
         run_ff      <= '0;
         position_ff <= '0;
      end else begin
         older_ff    <= older_in;
         newer_ff    <= newer_in;
         rising_ff   <= rising_in;
         run_ff      <= run_in;
         position_ff <= position_in;
      end
   end

endmodule
`default_nettype wire

[rtl/ptd_out_reg.sv]
// Result register with valid and stall handshake.
`default_nettype none
module ptd_out_reg (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      load,
   input  wire ptd_pkg::result_type load_data,
   input  wire                      rsp_stall,
   output logic                     rsp_valid,
   output ptd_pkg::result_type      rsp_data,
   output logic                     busy
);
   import ptd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // The register is busy while it holds a beat the receiver has not taken.
   assign busy     = valid_ff && rsp_stall;
   assign valid_in = load || busy;
   assign data_in  = load ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

[rtl/peak_trough_detector_top.sv]
// Top level of the peak and trough detector.
//
// Use: signed 16-bit samples enter on the req_ channel (req_valid, req_stall,
// req_sample). Every accepted sample gives exactly one beat on the rsp_
// channel (rsp_valid, rsp_stall, rsp_found, rsp_kind, rsp_extremum_value,
// rsp_position). rsp_found is high when the sample closes a peak or trough
// whose run exceeded min_run; otherwise the other fields are zero.
// min_run is to be written through csr_wr_en and csr_wr_data only while the
// block idles; the block does not enforce this. A beat accepted is shown on
// rsp_ in the next cycle. Throughput is one sample per cycle while the
// receiver does not stall; the tracker state updates in the accepting cycle
// and a single result register holds the outgoing beat. When the receiver
// stalls a held beat, req_stall rises in the same cycle and no sample is
// taken until the result register drains. Reset (synchronous, active high)
// clears the samples, run counter and position, sets the direction to rising,
// sets min_run to 4 and empties the result register.
`default_nettype none
module peak_trough_detector_top (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_valid,
   output logic                                       req_stall,
   input  wire logic signed [ptd_pkg::SampleWidth-1:0] req_sample,
   output logic                                       rsp_valid,
   input  wire                                        rsp_stall,
   output logic                                       rsp_found,
   output logic                                       rsp_kind,
   output logic signed [ptd_pkg::SampleWidth-1:0]     rsp_extremum_value,
   output logic [ptd_pkg::PositionWidth-1:0]          rsp_position,
   input  wire                                        csr_wr_en,
   input  wire logic [ptd_pkg::RunWidth-1:0]          csr_wr_data
);
   import ptd_pkg::*;

   logic [RunWidth-1:0] min_run_ff, min_run_in;
   logic                accept;
   logic                busy;
   result_type          result;
   result_type          rsp_data;

   // Configuration register.
   assign min_run_in = csr_wr_en ? csr_wr_data : min_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= MinRunReset;
      end else begin
         min_run_ff <= min_run_in;
      end
   end

   // Input handshake.
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   ptd_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .sample  (req_sample),
      .min_run (min_run_ff),
      .result  (result)
   );

   ptd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .busy      (busy)
   );

   // Result fields.
   assign rsp_found          = rsp_data.found;
   assign rsp_kind           = rsp_data.kind;
   assign rsp_extremum_value = rsp_data.extremum_value;
   assign rsp_position       = rsp_data.position;

endmodule
`default_nettype wire

[rtl/ptd_checker.sv]
// Port-level checker for the peak and trough detector, bound to the top level.
`default_nettype none
`include "peak_trough_detector_top_assert.svh"
module ptd_checker (
   input wire                                        clock,
   input wire                                        reset,
   input wire                                        req_valid,
   input wire                                        req_stall,
   input wire                                        rsp_valid,
   input wire                                        rsp_stall,
   input wire                                        rsp_found,
   input wire                                        rsp_kind,
   input wire logic [ptd_pkg::SampleWidth-1:0]       rsp_extremum_value,
   input wire logic [ptd_pkg::PositionWidth-1:0]     rsp_position
);
   logic fields_zero;

   // All result fields besides found are zero.
   assign fields_zero = !rsp_kind && rsp_extremum_value == '0 && rsp_position == '0;

   // A beat without an extremum carries zero fields.
   `PTD_ASSERT_IMPLIES(a_zero_fields, rsp_valid && !rsp_found, fields_zero)

   // Input stalls only behind a held result beat.
   `PTD_ASSERT_IMPLIES(a_stall_cause, req_stall, rsp_valid && rsp_stall)

   // Every accepted sample shows a result beat in the next cycle.
   `PTD_ASSERT_NEXT(a_result_follows, req_valid && !req_stall, rsp_valid)

   // A stalled result beat stays valid with found and position unchanged.
   `PTD_ASSERT_NEXT(a_hold_beat, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_position))

   // Reset empties the result register.
   `PTD_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

endmodule

bind peak_trough_detector_top ptd_checker u_ptd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_found          (rsp_found),
   .rsp_kind           (rsp_kind),
   .rsp_extremum_value (rsp_extremum_value),
   .rsp_position       (rsp_position)
);
`default_nettype wire

[sim/tb_peak_trough_detector_top.sv]
// Self-checking testbench of the peak and trough detector, with a scoreboard that tracks the samples.
`default_nettype none
module tb_peak_trough_detector_top;
   import ptd_pkg::*;

   localparam int unsigned CycleLimit = 5_000_000;
   localparam int unsigned PrintLimit = 200;

   // Tracks the detector state and holds the result beats still to come.
   class extremum_scoreboard;
      logic [RunWidth-1:0]            min_run;
      logic signed [SampleWidth-1:0]  older;
      logic signed [SampleWidth-1:0]  newer;
      bit                             rising;
      logic [RunWidth-1:0]            run_count;
      logic [PositionWidth-1:0]       consumed;
      result_type                     expected_q[$];
      int unsigned                    errors;
      int unsigned                    beats;
      int unsigned                    peaks;
      int unsigned                    troughs;
      int unsigned                    quiet_breaks;

      function new();
         min_run = MinRunReset;
         older = '0;
         newer = '0;
         rising = 1'b1;
         run_count = '0;
         consumed = '0;
         errors = 0;
         beats = 0;
         peaks = 0;
         troughs = 0;
         quiet_breaks = 0;
      endfunction

      function void write_min_run(logic [RunWidth-1:0] value);
         min_run = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Checks the held pair against the direction, then shifts the sample in.
      function void note_sample(logic signed [SampleWidth-1:0] sample);
         result_type want;
         want = '0;
         if (rising && older > newer) begin
            if (run_count > min_run) begin
               want.found = 1'b1;
               want.kind = KIND_PEAK;
               want.extremum_value = older;
               want.position = consumed;
               peaks++;
            end else begin
               quiet_breaks++;
            end
            rising = 1'b0;
            run_count = '0;
         end else if (!rising && older < newer) begin
            if (run_count > min_run) begin
               want.found = 1'b1;
               want.kind = KIND_TROUGH;
               want.extremum_value = older;
               want.position = consumed;
               troughs++;
            end else begin
               quiet_breaks++;
            end
            rising = 1'b1;
            run_count = '0;
         end
         if (run_count != RunMax) begin
            run_count = run_count + 1'b1;
         end
         older = newer;
         newer = sample;
         consumed = consumed + 1'b1;
         expected_q.insert(expected_q.size(), want);
      endfunction

      function void compare_field(string name, logic signed [32:0] want,
                                  logic signed [32:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= PrintLimit) begin
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
         end
      endfunction

      // Compares one accepted result beat with the oldest expectation.
      function void check_beat(result_type got);
         result_type want;
         beats++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= PrintLimit) begin
               $display("%0t: unexpected beat, expected none, actual found %0d value %0d",
                        $time, got.found, got.extremum_value);
            end
            return;
         end
         want = expected_q.pop_front();
         compare_field("found", want.found, got.found);
         compare_field("kind", want.kind, got.kind);
         compare_field("extremum_value", want.extremum_value, got.extremum_value);
         compare_field("position", want.position, got.position);
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic signed [SampleWidth-1:0]    req_sample = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_found;
   logic                             rsp_kind;
   logic signed [SampleWidth-1:0]    rsp_extremum_value;
   logic [PositionWidth-1:0]         rsp_position;
   logic                             csr_wr_en = 1'b0;
   logic [RunWidth-1:0]              csr_wr_data = '0;

   extremum_scoreboard               board;
   logic signed [SampleWidth-1:0]    stim_q[$];
   int unsigned                      cycle_count = 0;
   int unsigned                      settings_used = 0;
   int                               stall_mode = 0;
   int                               mode_left = 0;

   peak_trough_detector_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_kind           (rsp_kind),
      .rsp_extremum_value (rsp_extremum_value),
      .rsp_position       (rsp_position),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver switches between stall patterns: none, light, heavy and a square wave.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         mode_left <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= mode_left[3];
         endcase
      end
   end

   // Every handshake is observed here with the values from before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            board.write_min_run(csr_wr_data);
         end
         if (req_valid && !req_stall) begin
            board.note_sample(req_sample);
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_beat({rsp_found, rsp_kind, rsp_extremum_value, rsp_position});
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Sends the queued samples in bursts of random length, with random gaps unless no_gaps is set.
   task automatic drive_samples(input bit no_gaps);
      int burst_left;
      burst_left = 0;
      while (stim_q.size() != 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!no_gaps && $urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         req_valid <= 1'b1;
         req_sample <= stim_q.pop_front();
         do @(posedge clock); while (req_stall);
         burst_left--;
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_min_run_reg(input logic [RunWidth-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Builds a waveform of ramps, plateaus and noise so that runs of many lengths break.
   function automatic void add_waveform(int count);
      int level;
      int step;
      int seg_len;
      int shape;
      int added;
      level = int'($urandom_range(0, 65535)) - 32768;
      added = 0;
      while (added < count) begin
         shape = $urandom_range(0, 9);
         seg_len = $urandom_range(1, 12);
         step = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 2000);
         for (int i = 0; i < seg_len && added < count; i++) begin
            if (shape == 9) begin
               level = int'($urandom_range(0, 65535)) - 32768;
            end else if (shape != 8 && $urandom_range(0, 7) != 0) begin
               level += (shape < 4) ? step : -step;
            end
            if (level > 32767) level = 32767;
            if (level < -32768) level = -32768;
            stim_q.insert(stim_q.size(), SampleWidth'(level));
            added++;
         end
      end
   endfunction

   initial begin
      int corner_samples[$];
      logic [RunWidth-1:0] setting;
      corner_samples = '{-32768, -20000, -10000, -10000, 0, 10000, 32767, 32767, 20000,
                         5000, 5000, -100, -32768, -32768, -5000, 3, 2, 3, 1, 32767,
                         -32768, 32767, -1, 0};
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset min_run: extremes, plateaus, long and short runs.
      foreach (corner_samples[i]) begin
         stim_q.insert(stim_q.size(), SampleWidth'(corner_samples[i]));
      end
      drive_samples(1'b0);
      wait_drained();

      // Random waveforms, one min_run setting per phase.
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: setting = '0;
            1: setting = RunWidth'(1);
            2: setting = RunMax;
            3: setting = RunWidth'(2);
            4: setting = RunWidth'(3);
            9: setting = RunWidth'($urandom_range(9, 65534));
            default: setting = RunWidth'($urandom_range(0, 8));
         endcase
         write_min_run_reg(setting);
         add_waveform(115);
         drive_samples(1'b0);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      $display("Checked %0d result beats across %0d min_run settings under varied stalls.",
               board.beats, settings_used);
      $display("Qualified peaks %0d, qualified troughs %0d, unqualified breaks %0d.",
               board.peaks, board.troughs, board.quiet_breaks);
      if (board.pending() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, board.pending());
      end
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire
